### hdl/um_register_execute_unit_macros.svh
// Assertion macros shared by the register execute unit RTL.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef UM_REGISTER_EXECUTE_UNIT_MACROS_SVH
`define UM_REGISTER_EXECUTE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checking off while in reset
`define UMRE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("umre: assertion failed");
// same-cycle implication, checking off while in reset
`define UMRE_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("umre: implication failed");
`else
`define UMRE_ASSERT(name, prop)
`define UMRE_IMPLY(name, ante, cons)
`endif
`endif

### hdl/umre_pkg.sv
// Shared types and constants for the register execute unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package umre_pkg;

  localparam int WORD_W      = 32;
  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int KIND_W      = 3;
  localparam int IMM_W       = 25;
  localparam int DIV_CNT_W   = $clog2(WORD_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // stream widths: fields packed from bit 0, padded to whole bytes
  localparam int S_TDATA_W = 40;  // dest, left, right, immediate
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 72;  // index, value, counter
  localparam int M_TUSER_W = 2;   // wrote, divide fault
  localparam int M_PAD_W   = M_TDATA_W - REG_IDX_W - 2 * WORD_W;

  // instruction kind codes on the input
  localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NAND  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LOADI = 3'd5;

  // classified operation
  typedef enum logic [2:0] {
    OP_MOVE,
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_NAND,
    OP_LOADI,
    OP_NOP
  } op_t;

  // queued micro-op
  typedef struct packed {
    op_t                  op;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] left;
    logic [REG_IDX_W-1:0] right;
    logic [IMM_W-1:0]     imm;
  } uop_t;

  // one result item
  typedef struct packed {
    logic                 wrote;
    logic [REG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    value;
    logic [WORD_W-1:0]    counter;
    logic                 fault;
  } res_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### hdl/umre_front.sv
// Front end: accepts instruction items, classifies the kind, and queues micro-ops.
// Depends on umre_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "um_register_execute_unit_macros.svh"
module umre_front import umre_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // dest[2:0], left[5:3], right[8:6], imm[33:9]
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // kind[2:0]
  output logic                      uop_valid,
  input  wire logic                 uop_ready,
  output uop_t                      uop
);

  uop_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  uop_t              decoded;
  logic              push;
  logic              pop;

  // classify the kind and unpack the operand fields
  always_comb begin
    decoded.dest  = s_tdata[REG_IDX_W-1:0];
    decoded.left  = s_tdata[2*REG_IDX_W-1:REG_IDX_W];
    decoded.right = s_tdata[3*REG_IDX_W-1:2*REG_IDX_W];
    decoded.imm   = s_tdata[3*REG_IDX_W+IMM_W-1:3*REG_IDX_W];
    case (s_tuser)
      KIND_MOVE:  decoded.op = OP_MOVE;
      KIND_ADD:   decoded.op = OP_ADD;
      KIND_MUL:   decoded.op = OP_MUL;
      KIND_DIV:   decoded.op = OP_DIV;
      KIND_NAND:  decoded.op = OP_NAND;
      KIND_LOADI: decoded.op = OP_LOADI;
      default:    decoded.op = OP_NOP;
    endcase
  end

  assign s_tready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign uop_valid = (count != '0);
  assign uop       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = uop_valid && uop_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `UMRE_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + QCNT_W'(1))
  `UMRE_IMPLY(a_ptr_gap, count == '0, wr_ptr == rd_ptr)
  `UMRE_ASSERT(a_count_max, count <= QCNT_W'(QUEUE_DEPTH))

endmodule
`default_nettype wire

### hdl/umre_div.sv
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
// Depends on umre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module umre_div import umre_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output div_stat_t              stat,
  output logic [WORD_W-1:0]      quotient
);

  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;

  // one trial subtraction
  assign shifted = {rem, quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], !diff[WORD_W]};
    end
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CNT_W'(WORD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

### hdl/umre_back.sv
// Back end: register file, program counter, execute sequencer and output register.
// Depends on umre_pkg, umre_div and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "um_register_execute_unit_macros.svh"
module umre_back import umre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic uop_valid,
  output logic      uop_ready,
  input  wire uop_t uop,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_DIV,
    S_FIN
  } state_t;

  state_t               state;
  uop_t                 cur;
  logic [WORD_W-1:0]    rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;
  logic [WORD_W-1:0]    rd0;
  logic [WORD_W-1:0]    rd1;
  logic                 rd0_en;
  logic [REG_IDX_W-1:0] rd0_addr;
  logic                 rf_we;
  logic [WORD_W-1:0]    res_value;
  logic                 res_wrote;
  logic                 res_fault;
  logic                 res_old;
  logic [WORD_W-1:0]    op_value;
  logic                 op_wrote;
  logic                 op_fault;
  logic                 op_old;
  logic [WORD_W-1:0]    pc;
  logic [WORD_W-1:0]    mul_lo;
  logic                 out_free;
  logic                 fin_go;
  logic                 dispatch;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [WORD_W-1:0]    div_quo;

  // handshake and sequencing
  assign out_free  = !res_valid || res_ready;
  assign fin_go    = (state == S_FIN) && out_free;
  assign dispatch  = uop_valid && ((state == S_IDLE) || fin_go);
  assign uop_ready = dispatch;
  assign rf_we     = fin_go && res_wrote;
  assign div_start = (state == S_OP) && (cur.op == OP_DIV) && (rd1 != '0);
  assign mul_lo    = rd0 * rd1;

  // port 0 reads the source at dispatch, the destination during execute
  assign rd0_en   = dispatch || (state == S_OP);
  assign rd0_addr = (state == S_OP) ? cur.dest : uop.left;

  // register file write, with per-entry valid bits for the zero reset
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[cur.dest] <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[cur.dest] <= 1'b1;
    end
  end

  // registered reads, write-first on an address match
  always_ff @(posedge clk) begin
    if (rd0_en) begin
      if (rf_we && (cur.dest == rd0_addr)) begin
        rd0 <= res_value;
      end else begin
        rd0 <= rf_valid[rd0_addr] ? rf[rd0_addr] : '0;
      end
    end
    if (dispatch) begin
      if (rf_we && (cur.dest == uop.right)) begin
        rd1 <= res_value;
      end else begin
        rd1 <= rf_valid[uop.right] ? rf[uop.right] : '0;
      end
    end
  end

  umre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd0),
    .divisor  (rd1),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // combinational operation results; a divide only flags here, its quotient comes later
  always_comb begin
    op_value = rd0;
    op_wrote = 1'b1;
    op_fault = 1'b0;
    op_old   = 1'b0;
    case (cur.op)
      OP_MOVE: begin
        if (rd1 == '0) begin
          op_wrote = 1'b0;
          op_old   = 1'b1;
        end
      end
      OP_ADD:   op_value = rd0 + rd1;
      OP_MUL:   op_value = mul_lo;
      OP_NAND:  op_value = ~(rd0 & rd1);
      OP_LOADI: op_value = WORD_W'(cur.imm);
      OP_DIV: begin
        if (rd1 == '0) begin
          op_wrote = 1'b0;
          op_fault = 1'b1;
          op_old   = 1'b1;
        end
      end
      default: begin
        op_wrote = 1'b0;
        op_old   = 1'b1;
      end
    endcase
  end

  // execute sequencer, result holding and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pc        <= '0;
    end else begin
      if (fin_go) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (dispatch) begin
        cur <= uop;
      end
      case (state)
        S_IDLE: begin
          if (dispatch) begin
            state <= S_OP;
          end
        end
        S_OP: begin
          res_value <= op_value;
          res_wrote <= op_wrote;
          res_fault <= op_fault;
          res_old   <= op_old;
          state     <= div_start ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_value <= div_quo;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            res.wrote     <= res_wrote;
            res.index     <= cur.dest;
            res.value     <= res_old ? rd0 : res_value;
            res.counter   <= pc + WORD_W'(1);
            res.fault     <= res_fault;
            pc            <= pc + WORD_W'(1);
            state         <= dispatch ? S_OP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `UMRE_ASSERT(a_pc_step, fin_go |=> pc == $past(pc) + WORD_W'(1))
  `UMRE_IMPLY(a_fault_only_div, fin_go && res_fault, (cur.op == OP_DIV) && !res_wrote)
  `UMRE_IMPLY(a_div_in_state, div_stat.busy, state == S_DIV)

endmodule
`default_nettype wire

### hdl/um_register_execute_unit.sv
// Register execute unit for a 32-bit universal machine: eight registers and a counter.
// Top level; depends on umre_pkg, umre_front and umre_back.
//
// Usage:
//   Input stream s_*: one decoded instruction per item; s_tuser carries the kind,
//   s_tdata the register indexes and the 25-bit immediate.
//   Output stream m_*: exactly one result item per instruction, in order; m_tuser
//   carries the write and divide-fault flags, m_tdata the register index, its
//   value after the instruction and the program counter after it.
//   An accepted item passes through the queue, the operand read, the execute step
//   and the output register; a divide also waits in the radix-2 divider.
//   The single execute sequencer works on one item at a time (operand read, then execute),
//   taking the next as a result enters the output register; a divide holds it until done.
//   A two-entry queue decouples acceptance from execution.
//   Reset (rst, synchronous): registers and counter read as zero, queue empties,
//   no result pending.
//   If m_tready stays low, the finished result waits in the output register,
//   the sequencer holds the next one, and s_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module um_register_execute_unit import umre_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // dest[2:0], left[5:3], right[8:6], imm[33:9]
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // kind[2:0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // index[2:0], value[34:3], counter[66:35]
  output logic [M_TUSER_W-1:0]      m_tuser    // wrote[0], divide fault[1]
);

  uop_t uop;
  logic uop_valid;
  logic uop_ready;
  res_t res;

  umre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .uop_valid (uop_valid),
    .uop_ready (uop_ready),
    .uop       (uop)
  );

  umre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .uop_valid (uop_valid),
    .uop_ready (uop_ready),
    .uop       (uop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // pack the result item
  assign m_tdata = {{M_PAD_W{1'b0}}, res.counter, res.value, res.index};
  assign m_tuser = {res.fault, res.wrote};

endmodule
`default_nettype wire

### dv/umre_result_checker.sv
// Result checker for the register execute unit: shadows the registers and counter,
// predicts one result per accepted instruction and compares it with the output stream.
// Depends on umre_pkg for widths, kind codes and the result struct.
`timescale 1ns / 1ps
module umre_result_checker import umre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [M_TUSER_W-1:0] m_tuser,
  output int                   mismatch_count,
  output int                   pending_count,
  output int                   checked_count,
  output int                   fault_count
);

  // shadow machine state
  logic [WORD_W-1:0] shadow_regs [REG_COUNT];
  logic [WORD_W-1:0] shadow_counter;

  // results predicted but not yet seen, oldest first
  res_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    // keep the log short if everything goes wrong
    if (mismatch_count < 40)
      $display("umre_result_checker: %0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // executes one instruction on the shadow state and returns its result item
  function automatic res_t execute_register_op(input logic [KIND_W-1:0] kind,
                                               input logic [REG_IDX_W-1:0] dest,
                                               input logic [REG_IDX_W-1:0] left,
                                               input logic [REG_IDX_W-1:0] right,
                                               input logic [IMM_W-1:0] imm);
    res_t r;
    logic [WORD_W-1:0] vb;
    logic [WORD_W-1:0] vc;
    vb = shadow_regs[left];
    vc = shadow_regs[right];
    r.wrote = 1'b0;
    r.fault = 1'b0;
    r.index = dest;
    r.value = shadow_regs[dest];
    case (kind)
      KIND_MOVE: begin
        if (vc != '0) begin
          r.value = vb;
          r.wrote = 1'b1;
        end
      end
      KIND_ADD: begin
        r.value = vb + vc;
        r.wrote = 1'b1;
      end
      KIND_MUL: begin
        r.value = vb * vc;
        r.wrote = 1'b1;
      end
      KIND_DIV: begin
        // divide by zero flags and leaves the register alone
        if (vc == '0) begin
          r.fault = 1'b1;
        end else begin
          r.value = vb / vc;
          r.wrote = 1'b1;
        end
      end
      KIND_NAND: begin
        r.value = ~(vb & vc);
        r.wrote = 1'b1;
      end
      KIND_LOADI: begin
        r.value = {{(WORD_W-IMM_W){1'b0}}, imm};
        r.wrote = 1'b1;
      end
      default: ;
    endcase
    if (r.wrote)
      shadow_regs[dest] = r.value;
    shadow_counter = shadow_counter + WORD_W'(1);
    r.counter = shadow_counter;
    return r;
  endfunction

  // watch both channels; compare outputs before queuing the new prediction
  always @(posedge clk) begin : watch_channels
    res_t want;
    if (rst) begin
      foreach (shadow_regs[i])
        shadow_regs[i] = '0;
      shadow_counter = '0;
      expected_results.delete();
      pending_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata[34:3], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[0] !== want.wrote)
            report_mismatch("wrote flag", WORD_W'(m_tuser[0]), WORD_W'(want.wrote));
          if (m_tuser[1] !== want.fault)
            report_mismatch("divide fault", WORD_W'(m_tuser[1]), WORD_W'(want.fault));
          if (m_tdata[2:0] !== want.index)
            report_mismatch("written index", WORD_W'(m_tdata[2:0]), WORD_W'(want.index));
          if (m_tdata[34:3] !== want.value)
            report_mismatch("written value", m_tdata[34:3], want.value);
          if (m_tdata[66:35] !== want.counter)
            report_mismatch("next counter", m_tdata[66:35], want.counter);
          checked_count++;
          if (want.fault)
            fault_count++;
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(execute_register_op(s_tuser, s_tdata[2:0], s_tdata[5:3],
                                                       s_tdata[8:6], s_tdata[33:9]));
      pending_count = expected_results.size();
    end
  end

endmodule

### dv/tb_um_register_execute_unit.sv
// Testbench top for the register execute unit: clock, reset, instruction stimulus and
// output back-pressure; checking is done by umre_result_checker. Depends on umre_pkg.
`timescale 1ns / 1ps
module tb_um_register_execute_unit;
  import umre_pkg::*;

  // kinds with no operation behind them
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 80;
  localparam logic [IMM_W-1:0] IMM_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // dest[2:0], left[5:3], right[8:6], imm[33:9]
  logic [S_TUSER_W-1:0] s_tuser = '0;   // kind[2:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // index[2:0], value[34:3], counter[66:35]
  logic [M_TUSER_W-1:0] m_tuser;        // wrote[0], divide fault[1]

  int  mismatch_count;
  int  pending_count;
  int  checked_count;
  int  fault_count;
  int  kind_sent [8];
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  hold_outputs = 1'b0;

  always #1 clk = ~clk;

  um_register_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  umre_result_checker u_result_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .fault_count    (fault_count)
  );

  // offer one instruction; entered and left at a falling edge
  task automatic send_instr(input logic [KIND_W-1:0] kind, input logic [REG_IDX_W-1:0] dest,
                            input logic [REG_IDX_W-1:0] left,
                            input logic [REG_IDX_W-1:0] right,
                            input logic [IMM_W-1:0] imm);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W-IMM_W-3*REG_IDX_W){1'b0}}, imm, right, left, dest};
    do @(posedge clk); while (!s_tready);
    kind_sent[kind]++;
    @(negedge clk);
  endtask

  // receiver: random stall per item, plus long hold-offs on request
  initial begin : drain_outputs
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_outputs) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_outputs = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : drive_instructions
    int sel;
    logic [KIND_W-1:0]    kind;
    logic [IMM_W-1:0]     imm;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: zero registers first, then extremes of every kind
    send_instr(KIND_MOVE,   3'd1, 3'd2, 3'd3, '0);         // condition zero, no write
    send_instr(KIND_DIV,    3'd0, 3'd1, 3'd2, '0);         // divide by zero
    send_instr(KIND_LOADI,  3'd1, 3'd0, 3'd0, IMM_MAX);
    send_instr(KIND_LOADI,  3'd2, 3'd7, 3'd7, '0);
    send_instr(KIND_LOADI,  3'd3, 3'd0, 3'd0, 25'd1);
    send_instr(KIND_NAND,   3'd4, 3'd2, 3'd2, '0);         // all ones
    send_instr(KIND_ADD,    3'd5, 3'd4, 3'd3, '0);         // wraps to zero
    send_instr(KIND_ADD,    3'd6, 3'd4, 3'd4, '0);
    send_instr(KIND_MUL,    3'd7, 3'd4, 3'd4, '0);         // wraps to one
    send_instr(KIND_MUL,    3'd0, 3'd1, 3'd4, '0);
    send_instr(KIND_MOVE,   3'd0, 3'd1, 3'd3, '0);         // taken move
    send_instr(KIND_MOVE,   3'd0, 3'd4, 3'd2, '0);         // not taken
    send_instr(KIND_DIV,    3'd5, 3'd4, 3'd3, '0);         // all ones by one
    send_instr(KIND_DIV,    3'd6, 3'd1, 3'd4, '0);         // quotient zero
    send_instr(KIND_DIV,    3'd7, 3'd4, 3'd2, IMM_MAX);    // by zero, nonzero dest
    send_instr(KIND_SPARE6, 3'd4, 3'd1, 3'd3, IMM_MAX);
    send_instr(KIND_SPARE7, 3'd1, 3'd4, 3'd4, '0);
    send_instr(KIND_NAND,   3'd0, 3'd4, 3'd4, '0);         // result zero
    send_instr(KIND_LOADI,  3'd2, 3'd5, 3'd2, 25'h0AAAAAA);
    send_instr(KIND_LOADI,  3'd6, 3'd2, 3'd5, 25'h1555555);
    send_instr(KIND_DIV,    3'd3, 3'd3, 3'd3, '0);         // self divide
    send_instr(KIND_ADD,    3'd7, 3'd7, 3'd7, '0);         // all operands one register
    send_instr(KIND_DIV,    3'd2, 3'd6, 3'd2, '0);

    // random instruction stream
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // sender waits for the block to drain completely
      if (i == 300 || i == 800) begin
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      // long output hold-off while the sender keeps going
      if (i == 600 || i == 1000)
        hold_outputs = 1'b1;
      tx_idle = !(i >= 550 && i < 700);
      rx_idle = !(i >= 550 && i < 700);

      sel = $urandom_range(0, 99);
      if (sel < 12)      kind = KIND_MOVE;
      else if (sel < 27) kind = KIND_ADD;
      else if (sel < 42) kind = KIND_MUL;
      else if (sel < 56) kind = KIND_DIV;
      else if (sel < 70) kind = KIND_NAND;
      else               kind = KIND_LOADI;

      // small and zero values keep moves and divides interesting
      case ($urandom_range(0, 3))
        0:       imm = '0;
        1:       imm = IMM_MAX;
        2:       imm = IMM_W'($urandom_range(0, 15));
        default: imm = IMM_W'($urandom);
      endcase
      send_instr(kind, REG_IDX_W'($urandom_range(0, 7)), REG_IDX_W'($urandom_range(0, 7)),
                 REG_IDX_W'($urandom_range(0, 7)), imm);
    end
    s_tvalid <= 1'b0;

    // wait for the last results, then allow a divide's worth of quiet time
    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("covered: move %0d, add %0d, mul %0d, div %0d, nand %0d, loadi %0d, spare %0d",
             kind_sent[KIND_MOVE], kind_sent[KIND_ADD], kind_sent[KIND_MUL],
             kind_sent[KIND_DIV], kind_sent[KIND_NAND], kind_sent[KIND_LOADI],
             kind_sent[KIND_SPARE6] + kind_sent[KIND_SPARE7]);
    $display("covered: %0d results checked, %0d divide faults, output hold-offs and drains",
             checked_count, fault_count);
    if (mismatch_count == 0) begin
      $display("tb_um_register_execute_unit: PASS");
    end else begin
      $display("tb_um_register_execute_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #600_000;
    $display("tb_um_register_execute_unit: FAIL");
    $finish;
  end

endmodule
